// ===== hdl/pdrcem_pkg.sv =====
package pdrcem_pkg;

	localparam int NUM_CHANNELS   = 37;
	localparam int WINDOW_LEN_DEF = 16;

	localparam int CNTR_W = 16;
	localparam int CH_W   = 6;
	localparam int MAP_W  = NUM_CHANNELS;
	localparam int MINS_W = 5;
	localparam int MINC_W = 6;
	localparam int CFGI_W = 2;
	localparam int CFGD_W = 6;
	localparam int PASS_W = $clog2(NUM_CHANNELS + 1);

	localparam logic [MAP_W-1:0]  ALL_CHANNELS = '1;
	localparam logic [CH_W-1:0]   LAST_CH      = CH_W'(NUM_CHANNELS - 1);
	localparam logic [MINS_W-1:0] MINS_RST     = MINS_W'(12);
	localparam logic [MINC_W-1:0] MINC_RST     = MINC_W'(2);

	typedef enum logic [CFGI_W-1:0] {
		CFG_MIN_SUCC = 2'd0,
		CFG_MIN_CH   = 2'd1
	} cfg_idx_t;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_FL_RD = 6'b000010,
		S_FL_WR = 6'b000100,
		S_SCAN  = 6'b001000,
		S_DRAIN = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	typedef struct packed {
		logic accept;
		logic fl_rd;
		logic fl_wr;
		logic scan;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic meas_flush;
		logic batch_go;
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

// ===== hdl/pdrcem_ram.sv =====
module pdrcem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 37
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/pdrcem_ctrl.sv =====
module pdrcem_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  pdrcem_pkg::sts_t  sts,
	output pdrcem_pkg::cmd_t  cmd
);
	import pdrcem_pkg::*;

	state_t state_q, state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.accept = in_valid && (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (cmd.accept && sts.meas_flush) begin
					state_d = S_FL_RD;
				end else if (cmd.accept && sts.batch_go) begin
					state_d = S_SCAN;
				end
			end
			S_FL_RD: begin
				cmd.fl_rd = 1'b1;
				state_d   = S_FL_WR;
			end
			S_FL_WR: begin
				cmd.fl_wr = 1'b1;
				state_d   = S_IDLE;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/pdrcem_dp.sv =====
module pdrcem_dp #(
	parameter int WINDOW_LEN = pdrcem_pkg::WINDOW_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pdrcem_pkg::cmd_t              cmd,
	output pdrcem_pkg::sts_t              sts,
	input  logic                          kind,
	input  logic [pdrcem_pkg::CNTR_W-1:0] evt_num,
	input  logic [pdrcem_pkg::CH_W-1:0]   channel,
	input  logic                          is_tx,
	input  logic                          success,
	input  logic [pdrcem_pkg::MAP_W-1:0]  current_map,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pdrcem_pkg::MAP_W-1:0]  channel_map,
	output logic                          map_changed,
	input  logic                          cfg_we,
	input  logic [pdrcem_pkg::CFGI_W-1:0] cfg_index,
	input  logic [pdrcem_pkg::CFGD_W-1:0] cfg_data
);
	import pdrcem_pkg::*;

	localparam int POS_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
	localparam int CMP_W  = (CNT_W > MINS_W) ? CNT_W : MINS_W;
	localparam int WORD_W = CNT_W + WINDOW_LEN;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LEN - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_LEN);

	logic [MINS_W-1:0] min_succ_q;
	logic [MINC_W-1:0] min_ch_q;

	logic [CNTR_W-1:0] pend_cnt_q;
	logic [CH_W-1:0]   pend_ch_q;
	logic              pend_out_q;
	logic              flushed_q;

	logic [CH_W-1:0]   fl_ch_q;
	logic              fl_bit_q;
	logic [MAP_W-1:0]  cur_q;

	logic [NUM_CHANNELS-1:0] win_vld_q;
	logic [NUM_CHANNELS-1:0] pos_vld_q;
	logic                    win_vld_s1;
	logic                    pos_vld_s1;

	logic [CH_W-1:0]   scan_idx_q;
	logic              scan_v_s1;
	logic [CH_W-1:0]   scan_ch_s1;
	logic [MAP_W-1:0]  map_q;
	logic [PASS_W-1:0] passing_q;

	logic              out_valid_q;
	logic [MAP_W-1:0]  channel_map_q;
	logic              map_changed_q;

	logic              counter_diff;
	logic              new_out;
	logic [CH_W-1:0]   win_raddr;
	logic              win_re;
	logic [WORD_W-1:0] win_rd;
	logic [WORD_W-1:0] win_wd;
	logic [POS_W-1:0]  pos_rd;
	logic [POS_W-1:0]  pos_wd;

	logic [WINDOW_LEN-1:0] win_cur;
	logic [WINDOW_LEN-1:0] win_new;
	logic [WINDOW_LEN-1:0] slot_mask;
	logic [CNT_W-1:0]      cnt_cur;
	logic [CNT_W-1:0]      cnt_new;
	logic [POS_W-1:0]      pos_cur;
	logic                  old_bit;
	logic                  ch_pass;
	logic                  fallback;
	logic [MAP_W-1:0]      map_fin;

	// decode of the incoming word
	assign counter_diff = (evt_num != pend_cnt_q);
	assign new_out      = is_tx ? success : (counter_diff ? 1'b0 : pend_out_q);

	assign sts.meas_flush = !kind && counter_diff && (pend_ch_q <= LAST_CH);
	assign sts.batch_go   = kind && flushed_q;
	assign sts.scan_last  = (scan_idx_q == LAST_CH);
	assign sts.out_free   = !out_valid_q || !out_stall;

	// window memories
	assign win_re    = cmd.fl_rd || cmd.scan;
	assign win_raddr = cmd.scan ? scan_idx_q : fl_ch_q;

	pdrcem_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NUM_CHANNELS)
	) u_win_ram (
		.clk   (clk),
		.we    (cmd.fl_wr),
		.waddr (fl_ch_q),
		.wdata (win_wd),
		.re    (win_re),
		.raddr (win_raddr),
		.rdata (win_rd)
	);

	pdrcem_ram #(
		.WIDTH (POS_W),
		.DEPTH (NUM_CHANNELS)
	) u_pos_ram (
		.clk   (clk),
		.we    (cmd.fl_wr),
		.waddr (fl_ch_q),
		.wdata (pos_wd),
		.re    (cmd.fl_rd),
		.raddr (fl_ch_q),
		.rdata (pos_rd)
	);

	// unwritten entries read as the reset contents
	always_comb begin
		win_cur   = win_vld_s1 ? win_rd[WINDOW_LEN-1:0] : '1;
		cnt_cur   = win_vld_s1 ? win_rd[WORD_W-1:WINDOW_LEN] : CNT_FULL;
		pos_cur   = pos_vld_s1 ? pos_rd : '0;
		slot_mask = WINDOW_LEN'(1) << pos_cur;
		old_bit   = |(win_cur & slot_mask);
		win_new   = fl_bit_q ? (win_cur | slot_mask) : (win_cur & ~slot_mask);
		cnt_new   = cnt_cur - CNT_W'(old_bit) + CNT_W'(fl_bit_q);
		win_wd    = {cnt_new, win_new};
		pos_wd    = (pos_cur == POS_LAST) ? '0 : pos_cur + POS_W'(1);
		ch_pass   = (CMP_W'(cnt_cur) >= CMP_W'(min_succ_q));
		fallback  = (passing_q < min_ch_q);
		map_fin   = fallback ? ALL_CHANNELS : map_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_succ_q  <= MINS_RST;
			min_ch_q    <= MINC_RST;
			pend_cnt_q  <= '0;
			pend_ch_q   <= '0;
			pend_out_q  <= 1'b0;
			flushed_q   <= 1'b0;
			win_vld_q   <= '0;
			pos_vld_q   <= '0;
			scan_v_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MIN_SUCC: min_succ_q <= cfg_data[MINS_W-1:0];
					CFG_MIN_CH:   min_ch_q   <= cfg_data[MINC_W-1:0];
					default: ;
				endcase
			end
			if (cmd.accept && !kind) begin
				if (counter_diff) begin
					flushed_q <= 1'b1;
				end
				pend_cnt_q <= evt_num;
				pend_ch_q  <= channel;
				pend_out_q <= new_out;
			end
			if (cmd.accept && kind && flushed_q) begin
				flushed_q <= 1'b0;
			end
			if (cmd.fl_wr) begin
				win_vld_q[fl_ch_q] <= 1'b1;
				pos_vld_q[fl_ch_q] <= 1'b1;
			end
			scan_v_s1 <= cmd.scan;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				if (fallback) begin
					win_vld_q <= '0;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (win_re) begin
			win_vld_s1 <= win_vld_q[win_raddr];
		end
		if (cmd.fl_rd) begin
			pos_vld_s1 <= pos_vld_q[fl_ch_q];
		end
		if (cmd.accept && !kind && counter_diff) begin
			fl_ch_q  <= pend_ch_q;
			fl_bit_q <= pend_out_q;
		end
		if (cmd.accept && kind) begin
			cur_q      <= current_map;
			scan_idx_q <= '0;
			map_q      <= '0;
			passing_q  <= '0;
		end
		if (cmd.scan) begin
			scan_idx_q <= scan_idx_q + CH_W'(1);
		end
		scan_ch_s1 <= scan_idx_q;
		if (scan_v_s1 && ch_pass) begin
			map_q[scan_ch_s1] <= 1'b1;
			passing_q         <= passing_q + PASS_W'(1);
		end
		if (cmd.emit) begin
			channel_map_q <= map_fin;
			map_changed_q <= (map_fin != cur_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign channel_map = channel_map_q;
	assign map_changed = map_changed_q;

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fl_wr |-> (fl_ch_q <= LAST_CH))
		else $error("window write to a channel out of range");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> (scan_idx_q <= LAST_CH))
		else $error("scan index past last channel");

	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && fallback) |=> (win_vld_q == '0))
		else $error("fallback did not refill windows");

	a_flag_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(flushed_q) |-> $past(cmd.accept && kind))
		else $error("flush flag cleared outside a batch end");

endmodule

// ===== hdl/pdr_channel_exclusion_map_core.sv =====
// channel  direction  handshake            payload
// in       sink       in_valid/in_stall    kind, evt_num, channel, is_tx, success,
//                                          current_map
// out      source     out_valid/out_stall  channel_map, map_changed
// cfg      sink       cfg_we               cfg_index, cfg_data
//
// Measurement word: flushing an event on channel 0..36 adds S_FL_RD (RAM read), S_FL_WR (write).
// Batch-end word with a flush: S_SCAN does one window RAM read per channel, then S_DRAIN and
// S_EMIT; S_EMIT repeats as long as the previous map is held by out_stall.
// Reset: windows read as all ones through per-channel valid bits; no clearing pass.
// A held result does not block measurement words; only the next map waits on it.
module pdr_channel_exclusion_map_core #(
	parameter int WINDOW_LEN = pdrcem_pkg::WINDOW_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic [pdrcem_pkg::CNTR_W-1:0] evt_num,
	input  logic [pdrcem_pkg::CH_W-1:0]   channel,
	input  logic                          is_tx,
	input  logic                          success,
	input  logic [pdrcem_pkg::MAP_W-1:0]  current_map,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pdrcem_pkg::MAP_W-1:0]  channel_map,
	output logic                          map_changed,
	input  logic                          cfg_we,
	input  logic [pdrcem_pkg::CFGI_W-1:0] cfg_index,
	input  logic [pdrcem_pkg::CFGD_W-1:0] cfg_data
);
	import pdrcem_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pdrcem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	pdrcem_dp #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.kind        (kind),
		.evt_num     (evt_num),
		.channel     (channel),
		.is_tx       (is_tx),
		.success     (success),
		.current_map (current_map),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.channel_map (channel_map),
		.map_changed (map_changed),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

endmodule

// ===== tb/sv/tb_pdr_channel_exclusion_map_core.sv =====
module tb_pdr_channel_exclusion_map_core;
	timeunit 1ns;
	timeprecision 1ps;

	import pdrcem_pkg::*;

	localparam int WIN_LEN      = WINDOW_LEN_DEF;
	localparam int POS_W        = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
	localparam int CNT_W        = $clog2(WIN_LEN + 1);
	localparam int LIMIT_CYCLES = 1000000;
	localparam int DRAIN_CYCLES = 20000;
	localparam int TAIL_CYCLES  = 60;
	localparam int IDLE_CYCLES  = 48;

	localparam logic [CFGI_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFGI_W-1:0] CFG_SPARE_HI = 2'd3;

	typedef enum logic {
		KIND_MEAS      = 1'b0,
		KIND_BATCH_END = 1'b1
	} word_kind_t;

	typedef struct packed {
		word_kind_t         kind;
		logic [CNTR_W-1:0]  counter;
		logic [CH_W-1:0]    ch;
		logic               is_tx;
		logic               success;
		logic [MAP_W-1:0]   cur_map;
	} link_word_t;

	typedef struct packed {
		logic [MAP_W-1:0] map;
		logic             changed;
	} map_result_t;

	class exclusion_map_tracker;
		logic [WIN_LEN-1:0] outcome_bits [NUM_CHANNELS];
		logic [POS_W-1:0]   slot [NUM_CHANNELS];
		logic [CNT_W-1:0]   ones [NUM_CHANNELS];
		logic [CNTR_W-1:0]  pend_counter;
		logic [CH_W-1:0]    pend_ch;
		logic               pend_outcome;
		logic               flushed;
		logic [MINS_W-1:0]  min_succ;
		logic [MINC_W-1:0]  min_ch;
		logic [MAP_W-1:0]   last_map;
		map_result_t        maps_due [$];
		int                 errors;

		function new();
			refill();
			for (int i = 0; i < NUM_CHANNELS; i++)
				slot[i] = '0;
			pend_counter = '0;
			pend_ch      = '0;
			pend_outcome = 1'b0;
			flushed      = 1'b0;
			min_succ     = MINS_RST;
			min_ch       = MINC_RST;
			last_map     = ALL_CHANNELS;
			errors       = 0;
		endfunction

		function void refill();
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				outcome_bits[i] = '1;
				ones[i]         = CNT_W'(WIN_LEN);
			end
		endfunction

		function void write_reg(logic [CFGI_W-1:0] idx, logic [CFGD_W-1:0] data);
			case (idx)
			CFG_MIN_SUCC: begin
				min_succ = data[MINS_W-1:0];
			end
			CFG_MIN_CH: begin
				min_ch = data[MINC_W-1:0];
			end
			default: begin
			end
			endcase
		endfunction

		function void push(logic [CH_W-1:0] ch, logic outcome);
			logic [CNT_W-1:0] n;
			if (ch >= NUM_CHANNELS)
				return;
			outcome_bits[ch][slot[ch]] = outcome;
			slot[ch] = (slot[ch] == POS_W'(WIN_LEN - 1)) ? '0 : slot[ch] + 1'b1;
			n = '0;
			for (int b = 0; b < WIN_LEN; b++)
				n += CNT_W'(outcome_bits[ch][b]);
			ones[ch] = n;
		endfunction

		function void take_word(link_word_t w);
			logic [MAP_W-1:0] m;
			int passing;
			if (w.kind == KIND_MEAS) begin
				if (w.counter != pend_counter) begin
					push(pend_ch, pend_outcome);
					flushed      = 1'b1;
					pend_outcome = 1'b0;
				end
				pend_counter = w.counter;
				pend_ch      = w.ch;
				if (w.is_tx)
					pend_outcome = w.success;
				return;
			end
			if (!flushed)
				return;
			flushed = 1'b0;
			m       = '0;
			passing = 0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (ones[i] >= min_succ) begin
					m[i] = 1'b1;
					passing++;
				end
			end
			if (passing < int'(min_ch)) begin
				m = ALL_CHANNELS;
				refill();
			end
			last_map = m;
			maps_due.push_back('{m, m != w.cur_map});
		endfunction

		function void check_map(logic [MAP_W-1:0] map, logic changed);
			map_result_t e;
			if (maps_due.size() == 0) begin
				$error("unexpected word: channel_map %h map_changed %b", map, changed);
				errors++;
				return;
			end
			e = maps_due.pop_front();
			if (map !== e.map) begin
				$error("channel_map expected %h actual %h", e.map, map);
				errors++;
			end
			if (changed !== e.changed) begin
				$error("map_changed expected %b actual %b", e.changed, changed);
				errors++;
			end
		endfunction

		function int outstanding();
			return maps_due.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              kind;
	logic [CNTR_W-1:0] evt_num;
	logic [CH_W-1:0]   channel;
	logic              is_tx;
	logic              success;
	logic [MAP_W-1:0]  current_map;
	logic              out_valid;
	logic              out_stall;
	logic [MAP_W-1:0]  channel_map;
	logic              map_changed;
	logic              cfg_we;
	logic [CFGI_W-1:0] cfg_index;
	logic [CFGD_W-1:0] cfg_data;

	exclusion_map_tracker tracker = new();

	int                cycle_count;
	int                words_sent;
	int                burst_left;
	logic [CNTR_W-1:0] last_counter;
	int                quality [NUM_CHANNELS];
	logic [CH_W-1:0]   hot_channels [$];

	pdr_channel_exclusion_map_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.evt_num     (evt_num),
		.channel     (channel),
		.is_tx       (is_tx),
		.success     (success),
		.current_map (current_map),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.channel_map (channel_map),
		.map_changed (map_changed),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("tb_pdr_channel_exclusion_map_core NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_map(channel_map, map_changed);
	end

	// receiver back-pressure: free, light, heavy, and long fixed stall runs
	initial begin
		int mode;
		int seg;
		out_stall = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			seg  = $urandom_range(20, 200);
			for (int i = 0; i < seg; i++) begin
				@(negedge clk);
				case (mode)
				0: out_stall = 1'b0;
				1: out_stall = ($urandom_range(0, 3) == 0);
				2: out_stall = ($urandom_range(0, 3) != 0);
				default: out_stall = ((i % 48) < 40);
				endcase
			end
		end
	end

	function automatic logic [MAP_W-1:0] rand_map();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[MAP_W-1:0];
	endfunction

	function automatic link_word_t meas_word(logic [CNTR_W-1:0] cnt, logic [CH_W-1:0] ch,
			logic tx, logic ok);
		link_word_t w;
		w.kind    = KIND_MEAS;
		w.counter = cnt;
		w.ch      = ch;
		w.is_tx   = tx;
		w.success = ok;
		w.cur_map = rand_map();
		return w;
	endfunction

	function automatic link_word_t batch_word(logic [MAP_W-1:0] cur);
		link_word_t w;
		w.kind    = KIND_BATCH_END;
		w.counter = CNTR_W'($urandom());
		w.ch      = CH_W'($urandom_range(0, 63));
		w.is_tx   = 1'($urandom_range(0, 1));
		w.success = 1'($urandom_range(0, 1));
		w.cur_map = cur;
		return w;
	endfunction

	task automatic send_word(link_word_t w);
		kind          = w.kind;
		evt_num       = w.counter;
		channel       = w.ch;
		is_tx         = w.is_tx;
		success       = w.success;
		current_map   = w.cur_map;
		in_valid      = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		tracker.take_word(w);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic issue(link_word_t w);
		int gap;
		send_word(w);
		burst_left--;
		if (burst_left <= 0) begin
			in_valid = 1'b0;
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 10);
		end
	endtask

	task automatic wait_maps_done();
		in_valid = 1'b0;
		while (tracker.outstanding() != 0)
			@(negedge clk);
	endtask

	task automatic quiesce();
		wait_maps_done();
		repeat (IDLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(logic [CFGI_W-1:0] idx, logic [CFGD_W-1:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		tracker.write_reg(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic shuffle_link_quality();
		int n;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			case ($urandom_range(0, 3))
			0: quality[i] = 97;
			1: quality[i] = 80;
			2: quality[i] = 50;
			default: quality[i] = 10;
			endcase
		end
		hot_channels.delete();
		n = $urandom_range(3, 10);
		repeat (n) hot_channels.push_back(CH_W'($urandom_range(0, NUM_CHANNELS - 1)));
		last_counter = ($urandom_range(0, 3) == 0) ? CNTR_W'(16'hfff0) : CNTR_W'($urandom());
	endtask

	function automatic logic [CH_W-1:0] pick_channel();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return hot_channels[$urandom_range(0, hot_channels.size() - 1)];
		if (r < 93)
			return CH_W'($urandom_range(0, NUM_CHANNELS - 1));
		return CH_W'($urandom_range(NUM_CHANNELS, 63));
	endfunction

	task automatic run_traffic(int n);
		int target;
		int r;
		int n_events;
		int n_meas;
		int q;
		logic [CH_W-1:0]  ch;
		logic             tx;
		logic [MAP_W-1:0] cur;
		link_word_t       w;
		target = words_sent + n;
		while (words_sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				w.kind    = word_kind_t'($urandom_range(0, 1));
				w.counter = CNTR_W'($urandom());
				w.ch      = CH_W'($urandom_range(0, 63));
				w.is_tx   = 1'($urandom_range(0, 1));
				w.success = 1'($urandom_range(0, 1));
				w.cur_map = rand_map();
				issue(w);
			end else if (r < 6) begin
				issue(batch_word(rand_map()));
			end else begin
				n_events = $urandom_range(1, 12);
				for (int e = 0; e < n_events; e++) begin
					if ($urandom_range(0, 24) == 0)
						last_counter = CNTR_W'($urandom());
					else
						last_counter = last_counter + CNTR_W'($urandom_range(1, 4));
					ch = pick_channel();
					q = (ch < NUM_CHANNELS) ? quality[ch] : 50;
					n_meas = $urandom_range(1, 3);
					for (int k = 0; k < n_meas; k++) begin
						tx = ($urandom_range(0, 3) != 0);
						issue(meas_word(last_counter, ch, tx, $urandom_range(0, 99) < q));
					end
				end
				case ($urandom_range(0, 3))
				0, 1: cur = tracker.last_map;
				2: cur = rand_map();
				default: cur = tracker.last_map ^ (MAP_W'(1) << $urandom_range(0, MAP_W - 1));
				endcase
				issue(batch_word(cur));
				if ($urandom_range(0, 29) == 0)
					wait_maps_done();
			end
		end
	endtask

	task automatic run_phase(logic [CFGD_W-1:0] succ_data, logic [CFGD_W-1:0] ch_data, int n);
		quiesce();
		cfg_write(CFG_MIN_SUCC, succ_data);
		cfg_write(CFG_MIN_CH, ch_data);
		shuffle_link_quality();
		run_traffic(n);
	endtask

	initial begin
		int waited;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		kind          = 1'b0;
		evt_num       = '0;
		channel       = '0;
		is_tx         = 1'b0;
		success       = 1'b0;
		current_map   = '0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		words_sent    = 0;
		burst_left    = $urandom_range(1, 10);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// no flush yet: batch end is silent, then counter zero matches the pending event
		issue(batch_word(ALL_CHANNELS));
		issue(meas_word(16'h0000, 6'd0, 1'b1, 1'b0));
		issue(meas_word(16'hffff, 6'd36, 1'b0, 1'b1));
		issue(meas_word(16'hffff, 6'd5, 1'b1, 1'b1));
		issue(meas_word(16'h0001, 6'd63, 1'b1, 1'b1));
		issue(meas_word(16'h0002, 6'd37, 1'b0, 1'b0));
		issue(batch_word(ALL_CHANNELS));
		issue(batch_word('0));
		// out-of-range channel flushed, then channel 36 drops below threshold
		issue(meas_word(16'h0003, 6'd36, 1'b1, 1'b0));
		issue(meas_word(16'h0003, 6'd36, 1'b0, 1'b1));
		for (int i = 4; i < 10; i++)
			issue(meas_word(CNTR_W'(i), 6'd36, 1'b1, 1'b0));
		issue(batch_word(ALL_CHANNELS));
		issue(meas_word(16'h000a, 6'd0, 1'b1, 1'b1));
		issue(batch_word(tracker.last_map));

		shuffle_link_quality();
		run_traffic(400);
		run_phase(6'd0, 6'd0, 200);
		run_phase(6'h30, 6'd37, 200);
		run_phase(6'h3f, 6'd0, 150);
		quiesce();
		cfg_write(CFG_SPARE_LO, CFGD_W'($urandom()));
		cfg_write(CFG_SPARE_HI, 6'h3f);
		run_phase(CFGD_W'($urandom_range(8, 14)), 6'h3f, 150);
		repeat (4)
			run_phase(CFGD_W'($urandom_range(0, 16)), CFGD_W'($urandom_range(0, 37)), 160);

		in_valid = 1'b0;
		waited = 0;
		while (tracker.outstanding() != 0 && waited < DRAIN_CYCLES) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.outstanding() != 0) begin
			$error("%0d channel maps never arrived", tracker.outstanding());
			tracker.errors++;
		end
		if (tracker.errors == 0)
			$display("tb_pdr_channel_exclusion_map_core OK");
		else
			$display("tb_pdr_channel_exclusion_map_core NOT OK");
		$finish;
	end

endmodule
